>>> design/qrs_pkg.sv
package qrs_pkg;

  localparam int COEF_W = 16;
  localparam int FRAC_W = 16;
  localparam int ROOT_W = 41;

  // Discriminant b*b - 4*a*c as a signed value.
  localparam int DISC_W = 2 * COEF_W + 3;
  // Radicand is the non-negative discriminant scaled by 2^(2*FRAC_W).
  localparam int DMAG_W = 2 * COEF_W + 2;
  localparam int T_W    = DMAG_W + 2 * FRAC_W;
  localparam int SQ_N   = T_W / 2;
  localparam int REM_W  = SQ_N + 3;

  // Numerators -(b*2^F +/- s) as signed values and their magnitudes.
  localparam int NUM_W  = SQ_N + 3;
  localparam int NMAG_W = NUM_W - 1;
  localparam int DEN_W  = COEF_W + 1;
  localparam int DIV_N  = NMAG_W;

  localparam int IN_W   = 3 * COEF_W;
  localparam int OUT_W  = 88;

  typedef struct packed {
    logic                     deg;
    logic                     neg;
    logic                     zero;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
  } sq_side_t;

  typedef struct packed {
    logic [1:0]       cnt;
    logic             deg;
    logic             sgn1;
    logic             sgn2;
    logic [DEN_W-1:0] dmag;
  } dv_side_t;

endpackage

>>> design/quadratic_root_solver_top.sv
// Real roots of a*x^2 + b*x + c for signed 16-bit coefficients.
// Input channel s_*: one beat carries coef_a, coef_b and coef_c.
// Output channel m_*: one beat per input beat, in order, carrying root_count,
// root_first, root_second (signed, 16 fraction bits) and degenerate.
// Stages in order: a register for the two products, a register for the
// discriminant, the square root (one result bit per stage), a register to
// form the numerators, the two parallel dividers (one quotient bit per
// stage) and the output register.
// A new beat is accepted in every cycle in which m_tvalid is low or the output
// is being taken, so sustained throughput is one item per clock while m_tready is high.
// The whole pipeline advances on one enable. When m_tvalid is high and
// m_tready is low, every stage holds and s_tready drops; nothing is lost or
// repeated, and the pipeline resumes as soon as the output beat is taken.
// Reset clears every stage valid bit, so no beat is presented after reset
// until a new input beat has passed through.
module quadratic_root_solver_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // coef_a, coef_b, coef_c
  input  logic [qrs_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // root_count, root_first, root_second, degenerate, zero pad
  output logic [qrs_pkg::OUT_W-1:0] m_tdata
);
  import qrs_pkg::*;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 1: products.
  logic                       v1;
  logic signed [2*COEF_W-1:0] bb, ac;
  logic signed [COEF_W-1:0]   a1, b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
    if (en) begin
      bb <= $signed(s_tdata[2*COEF_W-1:COEF_W]) * $signed(s_tdata[2*COEF_W-1:COEF_W]);
      ac <= $signed(s_tdata[COEF_W-1:0]) * $signed(s_tdata[3*COEF_W-1:2*COEF_W]);
      a1 <= s_tdata[COEF_W-1:0];
      b1 <= s_tdata[2*COEF_W-1:COEF_W];
    end
  end

  // Stage 2: discriminant.
  logic                     v2;
  logic signed [DISC_W-1:0] disc;
  logic signed [COEF_W-1:0] a2, b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      disc <= {{3{bb[2*COEF_W-1]}}, bb} - {ac[2*COEF_W-1], ac, 2'b00};
      a2   <= a1;
      b2   <= b1;
    end
  end

  // Square root, one result bit per stage.
  logic             sq_v    [1:SQ_N];
  logic [T_W-1:0]   sq_t    [1:SQ_N];
  logic [REM_W-1:0] sq_rem  [1:SQ_N];
  logic [SQ_N-1:0]  sq_root [1:SQ_N];
  sq_side_t         sq_sd   [1:SQ_N];

  logic [T_W-1:0]   sq0_t;
  sq_side_t         sq0_sd;

  logic [T_W-1:0]   sqn_t    [0:SQ_N-1];
  logic [REM_W-1:0] sqn_rem  [0:SQ_N-1];
  logic [SQ_N-1:0]  sqn_root [0:SQ_N-1];

  function automatic void sq_step(
    input  logic [T_W-1:0]   t,
    input  logic [REM_W-1:0] rem,
    input  logic [SQ_N-1:0]  root,
    output logic [T_W-1:0]   t_next,
    output logic [REM_W-1:0] rem_next,
    output logic [SQ_N-1:0]  root_next
  );
    logic [REM_W-1:0] rsh, trial;
    logic             ge;
    rsh       = {rem[REM_W-3:0], t[T_W-1:T_W-2]};
    trial     = {1'b0, root, 2'b01};
    ge        = (rsh >= trial);
    rem_next  = ge ? rsh - trial : rsh;
    root_next = {root[SQ_N-2:0], ge};
    t_next    = {t[T_W-3:0], 2'b00};
  endfunction

  always_comb begin
    sq0_t      = disc[DISC_W-1] ? '0 : {disc[DMAG_W-1:0], {(2*FRAC_W){1'b0}}};
    sq0_sd.deg  = (a2 == '0);
    sq0_sd.neg  = disc[DISC_W-1];
    sq0_sd.zero = (disc == '0);
    sq0_sd.a    = a2;
    sq0_sd.b    = b2;
    sq_step(sq0_t, '0, '0, sqn_t[0], sqn_rem[0], sqn_root[0]);
    for (int i = 1; i < SQ_N; i++) begin
      sq_step(sq_t[i], sq_rem[i], sq_root[i], sqn_t[i], sqn_rem[i], sqn_root[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[1] <= 1'b0;
    end else if (en) begin
      sq_v[1] <= v2;
    end
    if (en) begin
      sq_t[1]    <= sqn_t[0];
      sq_rem[1]  <= sqn_rem[0];
      sq_root[1] <= sqn_root[0];
      sq_sd[1]   <= sq0_sd;
    end
    for (int i = 1; i < SQ_N; i++) begin
      if (rst) begin
        sq_v[i+1] <= 1'b0;
      end else if (en) begin
        sq_v[i+1] <= sq_v[i];
      end
      if (en) begin
        sq_t[i+1]    <= sqn_t[i];
        sq_rem[i+1]  <= sqn_rem[i];
        sq_root[i+1] <= sqn_root[i];
        sq_sd[i+1]   <= sq_sd[i];
      end
    end
  end

  // Numerators and divisor magnitude.
  logic                       vn;
  logic [NMAG_W-1:0]          nm1, nm2;
  dv_side_t                   nsd;
  logic signed [NUM_W-1:0]    bs, n1, n2;
  logic signed [DEN_W-1:0]    den;
  logic [1:0]                 cnt;
  sq_side_t                   ls;

  always_comb begin
    ls  = sq_sd[SQ_N];
    bs  = {{(NUM_W-COEF_W-FRAC_W){ls.b[COEF_W-1]}}, ls.b, {FRAC_W{1'b0}}};
    n1  = -(bs + $signed({3'b000, sq_root[SQ_N]}));
    n2  = $signed({3'b000, sq_root[SQ_N]}) - bs;
    den = {ls.a, 1'b0};
    if (ls.deg || ls.neg) begin
      cnt = 2'd0;
    end else if (ls.zero) begin
      cnt = 2'd1;
    end else begin
      cnt = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (en) begin
      vn <= sq_v[SQ_N];
    end
    if (en) begin
      nm1      <= n1[NUM_W-1] ? NMAG_W'(-n1) : NMAG_W'(n1);
      nm2      <= n2[NUM_W-1] ? NMAG_W'(-n2) : NMAG_W'(n2);
      nsd.cnt  <= cnt;
      nsd.deg  <= ls.deg;
      nsd.sgn1 <= n1[NUM_W-1] ^ den[DEN_W-1];
      nsd.sgn2 <= n2[NUM_W-1] ^ den[DEN_W-1];
      nsd.dmag <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    end
  end

  // Two restoring dividers, one quotient bit per stage.
  logic              dv_v  [1:DIV_N];
  logic [NMAG_W-1:0] dv_n1 [1:DIV_N];
  logic [NMAG_W-1:0] dv_n2 [1:DIV_N];
  logic [DEN_W-1:0]  dv_r1 [1:DIV_N];
  logic [DEN_W-1:0]  dv_r2 [1:DIV_N];
  logic [NMAG_W-1:0] dv_q1 [1:DIV_N];
  logic [NMAG_W-1:0] dv_q2 [1:DIV_N];
  dv_side_t          dv_sd [1:DIV_N];

  logic [DEN_W-1:0]  dvn_r1 [0:DIV_N-1];
  logic [DEN_W-1:0]  dvn_r2 [0:DIV_N-1];
  logic              dvn_g1 [0:DIV_N-1];
  logic              dvn_g2 [0:DIV_N-1];

  function automatic void dv_step(
    input  logic [DEN_W-1:0] rem,
    input  logic             nbit,
    input  logic [DEN_W-1:0] dmag,
    output logic [DEN_W-1:0] rem_next,
    output logic             ge
  );
    logic [DEN_W:0] r, d;
    d        = {1'b0, dmag};
    r        = {rem, nbit};
    ge       = (r >= d);
    rem_next = ge ? DEN_W'(r - d) : DEN_W'(r);
  endfunction

  always_comb begin
    dv_step('0, nm1[NMAG_W-1], nsd.dmag, dvn_r1[0], dvn_g1[0]);
    dv_step('0, nm2[NMAG_W-1], nsd.dmag, dvn_r2[0], dvn_g2[0]);
    for (int i = 1; i < DIV_N; i++) begin
      dv_step(dv_r1[i], dv_n1[i][NMAG_W-1], dv_sd[i].dmag, dvn_r1[i], dvn_g1[i]);
      dv_step(dv_r2[i], dv_n2[i][NMAG_W-1], dv_sd[i].dmag, dvn_r2[i], dvn_g2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[1] <= 1'b0;
    end else if (en) begin
      dv_v[1] <= vn;
    end
    if (en) begin
      dv_n1[1] <= {nm1[NMAG_W-2:0], 1'b0};
      dv_n2[1] <= {nm2[NMAG_W-2:0], 1'b0};
      dv_r1[1] <= dvn_r1[0];
      dv_r2[1] <= dvn_r2[0];
      dv_q1[1] <= {{(NMAG_W-1){1'b0}}, dvn_g1[0]};
      dv_q2[1] <= {{(NMAG_W-1){1'b0}}, dvn_g2[0]};
      dv_sd[1] <= nsd;
    end
    for (int i = 1; i < DIV_N; i++) begin
      if (rst) begin
        dv_v[i+1] <= 1'b0;
      end else if (en) begin
        dv_v[i+1] <= dv_v[i];
      end
      if (en) begin
        dv_n1[i+1] <= {dv_n1[i][NMAG_W-2:0], 1'b0};
        dv_n2[i+1] <= {dv_n2[i][NMAG_W-2:0], 1'b0};
        dv_r1[i+1] <= dvn_r1[i];
        dv_r2[i+1] <= dvn_r2[i];
        dv_q1[i+1] <= {dv_q1[i][NMAG_W-2:0], dvn_g1[i]};
        dv_q2[i+1] <= {dv_q2[i][NMAG_W-2:0], dvn_g2[i]};
        dv_sd[i+1] <= dv_sd[i];
      end
    end
  end

  // Output register: apply signs and clear unused roots.
  dv_side_t          fs;
  logic [ROOT_W-1:0] q1x, q2x, r1o, r2o;

  always_comb begin
    fs  = dv_sd[DIV_N];
    q1x = {{(ROOT_W-NMAG_W){1'b0}}, dv_q1[DIV_N]};
    q2x = {{(ROOT_W-NMAG_W){1'b0}}, dv_q2[DIV_N]};
    r1o = (fs.cnt == 2'd0) ? '0 : (fs.sgn1 ? -q1x : q1x);
    r2o = (fs.cnt != 2'd2) ? '0 : (fs.sgn2 ? -q2x : q2x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_v[DIV_N];
    end
    if (en) begin
      m_tdata <= {3'b000, fs.deg, r2o, r1o, fs.cnt};
    end
  end

endmodule

>>> verif/quadratic_root_solver_top_test.sv
`timescale 1ns / 1ps

module quadratic_root_solver_top_test;
  import qrs_pkg::*;

  localparam int LATENCY   = 72;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1450;
  localparam int N_TABLE   = 20;

  typedef struct packed {
    logic [1:0]              cnt;
    logic signed [ROOT_W-1:0] r1;
    logic signed [ROOT_W-1:0] r2;
    logic                    deg;
  } roots_t;

  typedef struct {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    bit                       typed;
    roots_t                   want;
  } coef_row_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;

  roots_t    roots_pending[$];
  int        n_errors;
  int        idle_cycles;
  bit        quiet_phase;
  coef_row_t coef_table[N_TABLE];

  quadratic_root_solver_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bitwise floor square root of a 128-bit radicand.
  function automatic logic [63:0] isqrt128(logic [127:0] t);
    logic [63:0]  s;
    logic [63:0]  cand;
    logic [127:0] sq;
    s = '0;
    for (int k = 63; k >= 0; k--) begin
      cand = s | (64'd1 << k);
      sq = {64'd0, cand} * {64'd0, cand};
      if (sq <= t) s = cand;
    end
    return s;
  endfunction

  function automatic logic signed [ROOT_W-1:0] clamp_root(logic signed [127:0] r);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (ROOT_W - 1)) - 1;
    lo = -hi - 1;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[ROOT_W-1:0];
  endfunction

  function automatic roots_t solve_quadratic(logic signed [COEF_W-1:0] a,
                                             logic signed [COEF_W-1:0] b,
                                             logic signed [COEF_W-1:0] c);
    roots_t              r;
    logic signed [127:0] disc;
    logic signed [127:0] bs;
    logic signed [127:0] den;
    logic signed [127:0] s;
    r = '0;
    if (a == 0) begin
      r.deg = 1'b1;
      return r;
    end
    disc = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
    if (disc < 0) return r;
    bs  = 128'(b) <<< FRAC_W;
    den = 128'sd2 * 128'(a);
    if (disc == 0) begin
      r.cnt = 2'd1;
      r.r1  = clamp_root(-bs / den);
      return r;
    end
    s = 128'(isqrt128(128'(disc) << (2 * FRAC_W)));
    r.cnt = 2'd2;
    r.r1  = clamp_root(-(bs + s) / den);
    r.r2  = clamp_root(-(bs - s) / den);
    return r;
  endfunction

  function automatic bit idle_now();
    return !quiet_phase && ($urandom_range(99) < 12);
  endfunction

  // Output side: random stalls, compare every beat with the oldest prediction.
  always @(posedge clk) begin
    roots_t got;
    roots_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !idle_now();
      if (m_tvalid && m_tready) begin
        got = {m_tdata[1:0], m_tdata[2 +: ROOT_W], m_tdata[2+ROOT_W +: ROOT_W],
               m_tdata[2+2*ROOT_W]};
        if (roots_pending.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, m_tdata);
          n_errors++;
        end else begin
          want = roots_pending.pop_front();
          if (got.cnt !== want.cnt) begin
            $display("%0t: root_count exp %0d got %0d", $time, want.cnt, got.cnt);
            n_errors++;
          end
          if (got.r1 !== want.r1) begin
            $display("%0t: root_first exp %0d got %0d", $time, want.r1, got.r1);
            n_errors++;
          end
          if (got.r2 !== want.r2) begin
            $display("%0t: root_second exp %0d got %0d", $time, want.r2, got.r2);
            n_errors++;
          end
          if (got.deg !== want.deg) begin
            $display("%0t: degenerate exp %0d got %0d", $time, want.deg, got.deg);
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Holds one beat until it is taken; random gaps in front of it.
  task automatic send_coefs(logic signed [COEF_W-1:0] a, logic signed [COEF_W-1:0] b,
                            logic signed [COEF_W-1:0] c, bit typed, roots_t want);
    roots_t pred;
    while (idle_now()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    pred = solve_quadratic(a, b, c);
    if (typed && pred !== want) begin
      $display("%0t: table row a=%0d b=%0d c=%0d exp %h predicted %h",
               $time, a, b, c, want, pred);
      n_errors++;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {c, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    roots_pending.push_back(pred);
  endtask

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(5))
      0: return COEF_W'($urandom_range(7)) - 16'sd3;
      1: return 16'sh7fff;
      2: return 16'sh8000;
      3: return COEF_W'($urandom_range(255)) - 16'sd128;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  initial begin
    roots_t none;
    roots_t dbl;
    logic signed [COEF_W-1:0] ra;
    logic signed [COEF_W-1:0] rb;
    logic signed [COEF_W-1:0] rc;
    none = '0;
    n_errors = 0;
    quiet_phase = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;

    // Degenerate, negative discriminant, double roots, two distinct roots, extremes.
    coef_table[0]  = '{16'sd0, 16'sd5, 16'sd3, 1'b1, '{2'd0, '0, '0, 1'b1}};
    coef_table[1]  = '{16'sd0, 16'sh8000, 16'sh7fff, 1'b1, '{2'd0, '0, '0, 1'b1}};
    coef_table[2]  = '{16'sd1, 16'sd0, 16'sd1, 1'b1, none};
    coef_table[3]  = '{16'sh7fff, 16'sd0, 16'sh7fff, 1'b1, none};
    dbl = '{2'd1, 41'sd65536, '0, 1'b0};
    coef_table[4]  = '{16'sd1, -16'sd2, 16'sd1, 1'b1, dbl};
    dbl = '{2'd1, '0, '0, 1'b0};
    coef_table[5]  = '{16'sd1, 16'sd0, 16'sd0, 1'b1, dbl};
    coef_table[6]  = '{16'sd1, 16'sd0, -16'sd1, 1'b1, '{2'd2, -41'sd65536, 41'sd65536, 1'b0}};
    coef_table[7]  = '{-16'sd1, 16'sd3, -16'sd2, 1'b0, none};
    coef_table[8]  = '{16'sh8000, 16'sh8000, 16'sh7fff, 1'b0, none};
    coef_table[9]  = '{16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0, none};
    coef_table[10] = '{16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, none};
    coef_table[11] = '{16'sd1, 16'sh8000, 16'sh8000, 1'b0, none};
    coef_table[12] = '{-16'sd1, 16'sh7fff, 16'sh7fff, 1'b0, none};
    coef_table[13] = '{16'sh8000, 16'sd0, 16'sh7fff, 1'b0, none};
    coef_table[14] = '{16'sd1, 16'sd1, -16'sd1, 1'b0, none};
    coef_table[15] = '{16'sd3, 16'sd0, -16'sd7, 1'b0, none};
    coef_table[16] = '{-16'sd1, 16'sd0, 16'sd0, 1'b0, none};
    coef_table[17] = '{16'sh8000, 16'sd0, 16'sd0, 1'b0, none};
    coef_table[18] = '{16'sh7fff, 16'sd1, -16'sd1, 1'b0, none};
    coef_table[19] = '{-16'sd1, -16'sd1, 16'sh5555, 1'b0, none};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (coef_table[i])
      send_coefs(coef_table[i].a, coef_table[i].b, coef_table[i].c,
                 coef_table[i].typed, coef_table[i].want);

    // Let the pipeline drain completely once before the random part.
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (roots_pending.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet_phase = (n >= 400 && n < 700);
      ra = rand_coef();
      rb = rand_coef();
      rc = rand_coef();
      // Many perfect squares b^2 = 4ac give double roots.
      if ($urandom_range(9) == 0) begin
        ra = COEF_W'($urandom_range(40)) - 16'sd20;
        rc = ra * COEF_W'($urandom_range(20));
        rb = 16'sd0;
        for (int k = 0; k <= 200; k++)
          if (k * k == 4 * ra * rc) rb = COEF_W'(($urandom_range(1)) ? k : -k);
      end
      send_coefs(ra, rb, rc, 1'b0, none);
    end
    quiet_phase = 1'b0;
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (roots_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    if (n_errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
